@@ rtl/egv_pkg.sv @@
package egv_pkg;

	// Operand and product widths of the shared multiplier.
	localparam int unsigned MUL_W  = 35;
	localparam int unsigned PROD_W = 2 * MUL_W;

	// Width of the log-variance accumulator (Q.40 with headroom).
	localparam int unsigned ACC_W = 56;

	// log2(e) in Q1.30.
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	// Reset value of the expected absolute residual, 2/sqrt(2pi) in Q4.12.
	localparam logic [15:0] MEAN_ABS_RESET = 16'd3268;

	// Configuration register indexes.
	localparam logic [2:0] REG_LOG_CONST  = 3'd0;
	localparam logic [2:0] REG_THETA      = 3'd1;
	localparam logic [2:0] REG_GAMMA      = 3'd2;
	localparam logic [2:0] REG_MEAN_ABS   = 3'd3;
	localparam logic [2:0] REG_ARCH_ONE   = 3'd4;
	localparam logic [2:0] REG_ARCH_TWO   = 3'd5;
	localparam logic [2:0] REG_GARCH_ONE  = 3'd6;
	localparam logic [2:0] REG_GARCH_TWO  = 3'd7;

	// Root k of two in Q.30: c_0 = 2.0 and c_k = floor(sqrt(c_(k-1) * 2^30)).
	// Only ever called with constant arguments to build a table.
	function automatic logic [31:0] exp_root(input int k);
		logic [63:0] c;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		c = 64'd1 << 31;
		for (int j = 1; j <= 16; j++) begin
			if (j <= k) begin
				x = c << 30;
				r = '0;
				for (int i = 31; i >= 0; i--) begin
					b = 64'd1 << (2 * i);
					if (x >= r + b) begin
						x = x - (r + b);
						r = (r >> 1) + b;
					end else begin
						r = r >> 1;
					end
				end
				c = r;
			end
		end
		return c[31:0];
	endfunction

endpackage

@@ rtl/egv_in_if.sv @@
interface egv_in_if;
	logic               valid;
	logic               ready;
	logic               restart;
	logic signed [15:0] residual;

	modport source (output valid, output restart, output residual, input ready);
	modport sink   (input valid, input restart, input residual, output ready);
endinterface

@@ rtl/egv_out_if.sv @@
interface egv_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] log_variance;
	logic        [31:0] variance;
	logic               saturated;

	modport source (output valid, output log_variance, output variance, output saturated,
		input ready);
	modport sink   (input valid, input log_variance, input variance, input saturated,
		output ready);
endinterface

@@ rtl/egv_mul.sv @@
module egv_mul (
	input  logic                                 clk,
	input  logic signed [egv_pkg::MUL_W-1:0]     a,
	input  logic signed [egv_pkg::MUL_W-1:0]     b,
	output logic signed [egv_pkg::PROD_W-1:0]    prod_q
);

	// Registered signed product; the sequencer reads it in the cycle after issue.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

@@ rtl/egarch_variance_filter_top.sv @@
// EGARCH(2,2) conditional-variance filter. Each input transfer is one date: a restart
// transfer begins a new series and answers with log_const, any other transfer pushes the
// previous date's residual into the history and forms the new log variance from the
// ARCH and GARCH terms. One result transfer follows each input transfer. All products
// go through a single shared multiplier under a sequencer: two multiply-accumulate
// passes of four products each, a rounding step, one product for the base-two
// exponent and sixteen mantissa steps of the exponential, each product having an
// issue state and an absorb state, and a final state that loads the output register.
// An item is accepted only in the idle state, so the next input transfer waits until
// the sequencer is through with the last one. The input is ready again once the result
// sits in the output register, even if it has not yet been taken; a result still waiting
// there holds the next one in its final state.
module egarch_variance_filter_top #(
	parameter int unsigned ARCH_LAGS  = 2,
	parameter int unsigned GARCH_LAGS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_wdata,
	egv_in_if.sink      item_in,
	egv_out_if.source   result_out
);

	typedef enum logic [3:0] {
		S_IDLE, S_TH_MUL, S_TH_ACC, S_GA_MUL, S_GA_ACC, S_AR_MUL, S_AR_ACC,
		S_GR_MUL, S_GR_ACC, S_ROUND, S_EY_MUL, S_EY_ACC, S_EM_MUL, S_EM_ACC, S_FINAL
	} state_t;

	localparam int unsigned MW = egv_pkg::MUL_W;
	localparam int unsigned PW = egv_pkg::PROD_W;
	localparam int unsigned AW = egv_pkg::ACC_W;

	localparam logic [31:0] ROOT_TAB [16] = '{
		egv_pkg::exp_root(1),  egv_pkg::exp_root(2),  egv_pkg::exp_root(3),
		egv_pkg::exp_root(4),  egv_pkg::exp_root(5),  egv_pkg::exp_root(6),
		egv_pkg::exp_root(7),  egv_pkg::exp_root(8),  egv_pkg::exp_root(9),
		egv_pkg::exp_root(10), egv_pkg::exp_root(11), egv_pkg::exp_root(12),
		egv_pkg::exp_root(13), egv_pkg::exp_root(14), egv_pkg::exp_root(15),
		egv_pkg::exp_root(16)
	};

	// Configuration registers.
	logic signed [23:0] log_const_q;
	logic signed [15:0] theta_q, gamma_q, arch_one_q, arch_two_q, garch_one_q, garch_two_q;
	logic        [15:0] mean_abs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_const_q <= '0;
			theta_q     <= '0;
			gamma_q     <= '0;
			mean_abs_q  <= egv_pkg::MEAN_ABS_RESET;
			arch_one_q  <= '0;
			arch_two_q  <= '0;
			garch_one_q <= '0;
			garch_two_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				egv_pkg::REG_LOG_CONST: log_const_q <= cfg_wdata;
				egv_pkg::REG_THETA:     theta_q     <= cfg_wdata[15:0];
				egv_pkg::REG_GAMMA:     gamma_q     <= cfg_wdata[15:0];
				egv_pkg::REG_MEAN_ABS:  mean_abs_q  <= cfg_wdata[15:0];
				egv_pkg::REG_ARCH_ONE:  arch_one_q  <= cfg_wdata[15:0];
				egv_pkg::REG_ARCH_TWO:  arch_two_q  <= cfg_wdata[15:0];
				egv_pkg::REG_GARCH_ONE: garch_one_q <= cfg_wdata[15:0];
				egv_pkg::REG_GARCH_TWO: garch_two_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	state_t             state_q;
	logic signed [15:0] resid_hist_q [2];
	logic signed [23:0] lv_hist_q [2];
	logic        [1:0]  lag_cnt_q;
	logic               lag_q;
	logic signed [MW-1:0] t_q;
	logic signed [AW-1:0] acc_q;
	logic signed [23:0] lg_q;
	logic               sat_q;
	logic signed [9:0]  n_q;
	logic        [15:0] frac_q;
	logic        [32:0] m_q;
	logic        [3:0]  k_q;
	logic               out_valid_q;
	logic signed [23:0] out_lg_q;
	logic        [31:0] out_var_q;
	logic               out_sat_q;

	// Shared multiplier and its operand selection.
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;

	egv_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));

	logic signed [15:0] e_sel;
	logic        [16:0] e_abs;
	logic signed [17:0] e_dev;
	logic               arch_use, garch_use;
	logic signed [15:0] arch_sel, garch_sel;

	always_comb begin
		e_sel     = resid_hist_q[lag_q];
		e_abs     = e_sel[15] ? 17'(-{e_sel[15], e_sel}) : {1'b0, e_sel};
		e_dev     = $signed({1'b0, e_abs}) - $signed({2'b00, mean_abs_q});
		arch_use  = (32'(lag_q) < ARCH_LAGS) && ({1'b0, lag_q} < lag_cnt_q);
		garch_use = (32'(lag_q) < GARCH_LAGS) && ({1'b0, lag_q} < lag_cnt_q);
		arch_sel  = !arch_use ? '0 : (lag_q ? arch_two_q : arch_one_q);
		garch_sel = !garch_use ? '0 : (lag_q ? garch_two_q : garch_one_q);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TH_MUL: begin
				mul_a = MW'(theta_q);
				mul_b = MW'(e_sel);
			end
			S_GA_MUL: begin
				mul_a = MW'(gamma_q);
				mul_b = MW'(e_dev);
			end
			S_AR_MUL: begin
				mul_a = MW'(arch_sel);
				mul_b = t_q;
			end
			S_GR_MUL: begin
				mul_a = MW'(garch_sel);
				mul_b = MW'(lv_hist_q[lag_q]);
			end
			S_EY_MUL: begin
				mul_a = MW'(lg_q);
				mul_b = $signed({4'b0000, egv_pkg::LOG2E_Q30});
			end
			S_EM_MUL: begin
				mul_a = $signed({2'b00, m_q});
				mul_b = $signed({3'b000, ROOT_TAB[k_q]});
			end
			default: ;
		endcase
	end

	// Rounding and clipping of the accumulated log variance.
	logic signed [AW-1:0] acc_rnd;
	logic signed [31:0]   lg_full;
	logic                 lg_hi, lg_lo;
	logic signed [23:0]   lg_clip;

	always_comb begin
		acc_rnd = acc_q + (AW'(1) <<< 23);
		lg_full = acc_rnd[AW-1:24];
		lg_hi   = lg_full > 32'sd8388607;
		lg_lo   = lg_full < -32'sd8388608;
		lg_clip = lg_hi ? 24'h7FFFFF : (lg_lo ? 24'h800000 : lg_full[23:0]);
	end

	// Product rounding for the exponent and the mantissa steps.
	logic signed [PW-1:0] y_rnd;
	logic        [PW-1:0] m_rnd;

	always_comb begin
		y_rnd = prod_q + (PW'(1) <<< 29);
		m_rnd = $unsigned(prod_q) + (PW'(1) << 29);
	end

	// Final scaling of the mantissa by two to the power n.
	logic [33:0] var_wide;
	logic [10:0] shr;
	logic        var_over;

	always_comb begin
		shr      = 11'(11'sd14 - 11'(n_q));
		var_wide = '0;
		var_over = 1'b0;
		if (n_q >= 10'sd16) begin
			var_over = 1'b1;
		end else if (n_q >= 10'sd14) begin
			var_wide = {1'b0, m_q} << n_q[0];
			var_over = var_wide[33:32] != 2'b00;
		end else if (shr < 11'd32) begin
			var_wide = ({1'b0, m_q} + (34'd1 << (shr[4:0] - 5'd1))) >> shr[4:0];
		end
	end

	// The finished result enters the output register once it is free or being emptied.
	logic out_load;

	assign out_load = (state_q == S_FINAL) && (!out_valid_q || result_out.ready);

	// Sequencer, datapath registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			resid_hist_q <= '{default: '0};
			lv_hist_q    <= '{default: '0};
			lag_cnt_q    <= '0;
			lag_q        <= 1'b0;
			k_q          <= '0;
			sat_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_in.valid) begin
						if (item_in.restart) begin
							resid_hist_q <= '{default: '0};
							lv_hist_q    <= '{default: '0};
							lag_cnt_q    <= '0;
						end else begin
							resid_hist_q[1] <= resid_hist_q[0];
							resid_hist_q[0] <= item_in.residual;
							if (lag_cnt_q != 2'd2) begin
								lag_cnt_q <= lag_cnt_q + 2'd1;
							end
						end
						acc_q   <= {{(AW - 48){log_const_q[23]}}, log_const_q, 24'b0};
						lag_q   <= 1'b0;
						sat_q   <= 1'b0;
						state_q <= S_TH_MUL;
					end
				end
				S_TH_MUL: state_q <= S_TH_ACC;
				S_TH_ACC: begin
					t_q     <= prod_q[MW-1:0];
					state_q <= S_GA_MUL;
				end
				S_GA_MUL: state_q <= S_GA_ACC;
				S_GA_ACC: begin
					t_q     <= t_q + prod_q[MW-1:0];
					state_q <= S_AR_MUL;
				end
				S_AR_MUL: state_q <= S_AR_ACC;
				S_AR_ACC: begin
					acc_q   <= acc_q + prod_q[AW-1:0];
					state_q <= S_GR_MUL;
				end
				S_GR_MUL: state_q <= S_GR_ACC;
				S_GR_ACC: begin
					acc_q <= acc_q + {prod_q[AW-11:0], 10'b0};
					if (lag_q) begin
						state_q <= S_ROUND;
					end else begin
						lag_q   <= 1'b1;
						state_q <= S_TH_MUL;
					end
				end
				S_ROUND: begin
					lg_q         <= lg_clip;
					sat_q        <= lg_hi || lg_lo;
					lv_hist_q[1] <= lv_hist_q[0];
					lv_hist_q[0] <= lg_clip;
					state_q      <= S_EY_MUL;
				end
				S_EY_MUL: state_q <= S_EY_ACC;
				S_EY_ACC: begin
					n_q     <= y_rnd[55:46];
					frac_q  <= y_rnd[45:30];
					m_q     <= 33'd1 << 30;
					k_q     <= '0;
					state_q <= S_EM_MUL;
				end
				S_EM_MUL: state_q <= S_EM_ACC;
				S_EM_ACC: begin
					if (frac_q[~k_q]) begin
						m_q <= m_rnd[62:30];
					end
					k_q <= k_q + 4'd1;
					if (k_q == 4'd15) begin
						state_q <= S_FINAL;
					end else begin
						state_q <= S_EM_MUL;
					end
				end
				S_FINAL: begin
					if (out_load) begin
						out_lg_q    <= lg_q;
						out_var_q   <= var_over ? 32'hFFFF_FFFF : var_wide[31:0];
						out_sat_q   <= sat_q || var_over;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_in.ready           = state_q == S_IDLE;
	assign result_out.valid        = out_valid_q;
	assign result_out.log_variance = out_lg_q;
	assign result_out.variance     = out_var_q;
	assign result_out.saturated    = out_sat_q;

`ifndef SYNTHESIS
	a_lag_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		lag_cnt_q != 2'd3)
		else $error("lag count exceeds two");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.valid && item_in.ready |=> state_q == S_TH_MUL)
		else $error("accepted item did not start the sequencer");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.valid && item_in.ready && item_in.restart |=>
		lag_cnt_q == 2'd0 && lv_hist_q[0] == 24'sd0)
		else $error("restart did not clear the history");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINAL && (!out_valid_q || result_out.ready) |=>
		out_valid_q && state_q == S_IDLE)
		else $error("finished result not presented");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// One expected result of a date.
typedef struct {
	logic signed [23:0] log_variance;
	logic        [31:0] variance;
	logic               saturated;
} date_result_t;

// Tracks the filter state and the queue of expected conditional variances.
class variance_board;
	logic signed [23:0] log_const;
	logic signed [15:0] theta;
	logic signed [15:0] gamma;
	logic        [15:0] mean_abs;
	logic signed [15:0] arch_w [2];
	logic signed [15:0] garch_w [2];
	longint             eps_hist [2];
	longint             logh_hist [2];
	int                 lag_count;
	longint unsigned    roots [17];
	date_result_t       expected_dates [$];
	int                 errors;
	int                 checked;

	function new();
		longint unsigned c;
		log_const = '0;
		theta     = '0;
		gamma     = '0;
		mean_abs  = egv_pkg::MEAN_ABS_RESET;
		arch_w    = '{default: '0};
		garch_w   = '{default: '0};
		eps_hist  = '{default: 0};
		logh_hist = '{default: 0};
		lag_count = 0;
		errors    = 0;
		checked   = 0;
		// Successive square roots of two in Q.30 for the exponential.
		c = 64'd1 << 31;
		for (int k = 1; k <= 16; k++) begin
			c = int_sqrt(c << 30);
			roots[k] = c;
		end
	endfunction

	function longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function void write_reg(logic [2:0] idx, logic [23:0] d);
		case (idx)
			egv_pkg::REG_LOG_CONST: log_const  = d;
			egv_pkg::REG_THETA:     theta      = d[15:0];
			egv_pkg::REG_GAMMA:     gamma      = d[15:0];
			egv_pkg::REG_MEAN_ABS:  mean_abs   = d[15:0];
			egv_pkg::REG_ARCH_ONE:  arch_w[0]  = d[15:0];
			egv_pkg::REG_ARCH_TWO:  arch_w[1]  = d[15:0];
			egv_pkg::REG_GARCH_ONE: garch_w[0] = d[15:0];
			egv_pkg::REG_GARCH_TWO: garch_w[1] = d[15:0];
			default: ;
		endcase
	endfunction

	// Advance the history by one date and queue the variance it gives.
	function void note_input(bit restart, logic signed [15:0] eps);
		longint          acc;
		longint          lg;
		longint          e;
		longint          ae;
		longint          prod;
		longint          yb;
		longint          n;
		longint unsigned f;
		longint unsigned m;
		longint unsigned v;
		int              s;
		date_result_t    res;
		bit              sat;
		sat = 0;
		if (restart) begin
			eps_hist  = '{default: 0};
			logh_hist = '{default: 0};
			lag_count = 0;
		end else begin
			eps_hist[1] = eps_hist[0];
			eps_hist[0] = longint'(eps);
			if (lag_count < 2)
				lag_count++;
		end

		// Exact sum of the terms in Q.40.
		acc = longint'(log_const) * (longint'(1) <<< 24);
		for (int i = 0; i < lag_count; i++) begin
			e  = eps_hist[i];
			ae = (e < 0) ? -e : e;
			acc += longint'(arch_w[i]) *
				(longint'(theta) * e + longint'(gamma) * (ae - longint'(mean_abs)));
			acc += longint'(garch_w[i]) * logh_hist[i] * 1024;
		end

		// Round half up to Q8.16 and clip; the clipped value is what is stored.
		lg = (acc + (longint'(1) <<< 23)) >>> 24;
		if (lg > 8388607) begin
			lg  = 8388607;
			sat = 1;
		end else if (lg < -8388608) begin
			lg  = -8388608;
			sat = 1;
		end
		logh_hist[1] = logh_hist[0];
		logh_hist[0] = lg;

		// Base-two exponent with a square-root mantissa iteration.
		prod = lg * longint'(egv_pkg::LOG2E_Q30);
		yb   = (prod + (longint'(1) <<< 29)) >>> 30;
		n    = yb >>> 16;
		f    = yb & 64'hFFFF;
		m    = 64'd1 << 30;
		for (int k = 1; k <= 16; k++)
			if (f[16 - k])
				m = (m * roots[k] + (64'd1 << 29)) >> 30;
		if (n >= 16) begin
			v   = 64'hFFFF_FFFF;
			sat = 1;
		end else if (n >= 14) begin
			v = m << (n - 14);
		end else begin
			s = 14 - n;
			if (s >= 32)
				v = 0;
			else
				v = (m + (64'd1 << (s - 1))) >> s;
		end
		if (v > 64'hFFFF_FFFF) begin
			v   = 64'hFFFF_FFFF;
			sat = 1;
		end

		res.log_variance = lg[23:0];
		res.variance     = v[31:0];
		res.saturated    = sat;
		expected_dates.push_back(res);
	endfunction

	task report(string msg);
		$display("tb_top: mismatch: %s", msg);
		errors++;
	endtask

	task check_result(logic signed [23:0] lv, logic [31:0] var_q, logic sat);
		date_result_t exp_r;
		if (expected_dates.size() == 0) begin
			report("result transfer with no date outstanding");
		end else begin
			exp_r = expected_dates.pop_front();
			checked++;
			if (lv !== exp_r.log_variance)
				report($sformatf("log_variance %0d, wanted %0d", lv, exp_r.log_variance));
			if (var_q !== exp_r.variance)
				report($sformatf("variance %0h, wanted %0h", var_q, exp_r.variance));
			if (sat !== exp_r.saturated)
				report($sformatf("saturated %0b, wanted %0b", sat, exp_r.saturated));
		end
	endtask
endclass

module tb_top;
	localparam int CYCLE_LIMIT = 3_000_000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_wdata;

	egv_in_if  item_if ();
	egv_out_if res_if ();

	egarch_variance_filter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item_in    (item_if),
		.result_out (res_if)
	);

	variance_board board;
	int            cycles;
	int            sent;
	int            settings;
	int            burst_left;
	int            hold_left;
	bit            pressure_req;
	int            run_left;
	bit            run_state;
	bit            next_ready;

	// Clock and run limit.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Offer one date and wait for its transfer, then perhaps leave a gap.
	task send_date(bit r, logic [15:0] e);
		int gap;
		item_if.valid    <= 1'b1;
		item_if.restart  <= r;
		item_if.residual <= e;
		do @(posedge clk); while (!item_if.ready);
		board.note_input(r, e);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
			if (gap > 0) begin
				item_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 10);
		end
	endtask

	// Stop offering and wait until every date has its result.
	task drain;
		item_if.valid <= 1'b0;
		while (board.expected_dates.size() != 0)
			@(posedge clk);
	endtask

	task write_reg(logic [2:0] idx, logic [23:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		board.write_reg(idx, d);
	endtask

	task set_regs(logic [23:0] lc, logic [15:0] th, logic [15:0] ga, logic [15:0] ma,
		logic [15:0] a1, logic [15:0] a2, logic [15:0] g1, logic [15:0] g2);
		drain();
		write_reg(egv_pkg::REG_LOG_CONST, lc);
		write_reg(egv_pkg::REG_THETA, {8'h00, th});
		write_reg(egv_pkg::REG_GAMMA, {8'h00, ga});
		write_reg(egv_pkg::REG_MEAN_ABS, {8'h00, ma});
		write_reg(egv_pkg::REG_ARCH_ONE, {8'h00, a1});
		write_reg(egv_pkg::REG_ARCH_TWO, {8'h00, a2});
		write_reg(egv_pkg::REG_GARCH_ONE, {8'h00, g1});
		write_reg(egv_pkg::REG_GARCH_TWO, {8'h00, g2});
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic logic [15:0] small_coef();
		return 16'($signed($urandom_range(0, 8192)) - 4096);
	endfunction

	function automatic logic [15:0] any_resid();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($signed($urandom_range(0, 16384)) - 8192);
	endfunction

	// Receiver: checks each result transfer and stalls in runs of its own.
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready)
				board.check_result(res_if.log_variance, res_if.variance, res_if.saturated);
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (pressure_req) begin
				pressure_req = 1'b0;
				hold_left    = 600;
				next_ready   = 1'b0;
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 10);
					case ($urandom_range(0, 5))
						0: begin
							run_state = 1'b1;
							run_left  = 80;
						end
						1, 2: run_state = 1'b0;
						default: run_state = 1'b1;
					endcase
				end
				run_left--;
				next_ready = run_state;
			end
			res_if.ready <= next_ready;
		end
	end

	// Main sequence: directed dates, then random phases under varied settings.
	initial begin
		board            = new();
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = egv_pkg::REG_LOG_CONST;
		cfg_wdata        = '0;
		item_if.valid    = 1'b0;
		item_if.restart  = 1'b0;
		item_if.residual = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Dates before any restart use the zero history.
		send_date(1'b0, 16'h7FFF);
		send_date(1'b0, 16'h8000);
		send_date(1'b1, 16'h1234);
		send_date(1'b0, 16'h0000);

		// Largest and smallest log constant, then the edge of variance overflow.
		set_regs(24'h7FFFFF, 0, 0, 16'd3268, 0, 0, 0, 0);
		send_date(1'b1, 16'h0000);
		set_regs(24'h800000, 0, 0, 16'd3268, 0, 0, 0, 0);
		send_date(1'b1, 16'hFFFF);
		set_regs(24'd726817, 0, 0, 16'd3268, 0, 0, 0, 0);
		send_date(1'b1, 16'h0000);
		set_regs(24'd726830, 0, 0, 16'd3268, 0, 0, 0, 0);
		send_date(1'b1, 16'h0000);

		// Extreme weights over a long series, so clipped logs feed later dates.
		set_regs(24'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_date(1'b1, 16'h0000);
		send_date(1'b0, 16'h7FFF);
		send_date(1'b0, 16'h8000);
		send_date(1'b0, 16'h0000);
		send_date(1'b0, 16'hFFFF);
		send_date(1'b0, 16'h0001);
		send_date(1'b0, 16'h7FFF);
		send_date(1'b0, 16'h8000);

		// Random phases; the third one starts with a long receiver hold.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_regs(24'h7FFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
					16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
				1: set_regs(24'h800000, 16'h8000, 16'h8000, 16'h0000,
					16'h8000, 16'h8000, 16'h8000, 16'h8000);
				3: set_regs(24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				default: set_regs(24'($signed($urandom_range(0, 2097152)) - 1048576),
					small_coef(), small_coef(), 16'($urandom_range(0, 8192)),
					small_coef(), small_coef(), small_coef(), small_coef());
			endcase
			if (p == 2)
				pressure_req = 1'b1;
			for (int j = 0; j < 120; j++)
				send_date($urandom_range(0, 19) == 0, any_resid());
		end

		drain();
		repeat (60) @(posedge clk);
		$display("tb_top: %0d dates over %0d register settings, %0d results compared",
			sent, settings, board.checked);
		$display("tb_top: covered restarts, long series, clipped logs and variance bounds");
		if (board.errors == 0 && board.expected_dates.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule

@@ egarch_variance_filter_top.f @@
rtl/egv_pkg.sv
rtl/egv_in_if.sv
rtl/egv_out_if.sv
rtl/egv_mul.sv
rtl/egarch_variance_filter_top.sv
tb/tb_top.sv
